// ===== hdl/fpl_pkg.sv =====
// Shared types and constants for the frame pacing limiter.
// No dependencies; imported by fpl_serial_md and frame_pacing_limiter_top.
package fpl_pkg;

    localparam int unsigned TICK_W      = 32;
    localparam int unsigned TIME_W      = 64;
    localparam int unsigned ORIGIN_W    = 24;
    localparam int unsigned DELAY_W     = 31;
    localparam int unsigned SUM_W       = 34;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned HIST_DEPTH  = 4;
    localparam int unsigned HIST_LOG2   = 2;
    localparam int unsigned STEP_CNT_W  = 5;

    localparam logic [TICK_W:0]    GUARD_TICKS = 33'd50;
    localparam logic [SUM_W-1:0]   ROUND_BIAS  = 34'd2;
    localparam logic [DELAY_W-1:0] DELAY_MAX   = 31'h7FFF_FFFF;

    // speed_mode codes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BLANK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUX_SYNC        = 2'd2;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] dividend;
        logic [TICK_W-1:0] divisor;
        logic [TICK_W-1:0] multiplicand;
    } t_md_req;

    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] quotient;
        logic [TIME_W-1:0] product;
    } t_md_res;

endpackage

// ===== hdl/fpl_serial_md.sv =====
// Bit-serial divide and multiply unit: one quotient bit and one partial product per cycle during a run.
// Depends on fpl_pkg (t_md_req, t_md_res, widths).
module fpl_serial_md (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fpl_pkg::t_md_req i_req,
    output fpl_pkg::t_md_res o_res
);
    import fpl_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [TICK_W-1:0]     r_rem;
    logic [TICK_W-1:0]     r_quo;
    logic [TICK_W-1:0]     r_dvsr;
    logic [TICK_W-1:0]     r_mcand;
    logic [TIME_W-1:0]     r_prod;

    logic [TICK_W:0]       n_shifted;
    logic [TICK_W:0]       n_trial;
    logic                  n_ge;
    logic [TICK_W:0]       n_psum;

    // restoring division step; a zero divisor yields all ones
    assign n_shifted = {r_rem, r_quo[TICK_W-1]};
    assign n_trial   = n_shifted - {1'b0, r_dvsr};
    assign n_ge      = (n_shifted >= {1'b0, r_dvsr});

    // shift-add multiply step
    assign n_psum = {1'b0, r_prod[TIME_W-1:TICK_W]}
                  + {1'b0, (r_prod[0] ? r_mcand : {TICK_W{1'b0}})};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_CNT_W'(TICK_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem   <= '0;
            r_quo   <= i_req.dividend;
            r_dvsr  <= i_req.divisor;
            r_mcand <= i_req.multiplicand;
            r_prod  <= {{TICK_W{1'b0}}, i_req.divisor};
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_trial[TICK_W-1:0] : n_shifted[TICK_W-1:0];
            r_quo  <= {r_quo[TICK_W-2:0], n_ge};
            r_prod <= {n_psum, r_prod[TICK_W-1:1]};
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_quo;
    assign o_res.product  = r_prod;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("serial unit restarted while busy");
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("done without a finished run");
    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy && (r_cnt == STEP_CNT_W'(TICK_W - 1)))
        else $error("run did not begin with a full step count");
`endif

endmodule

// ===== hdl/frame_pacing_limiter_top.sv =====
// A blank with a new origin waits on the 32-step bit-serial divide/multiply unit,
// an unchanged origin does not; either may also wait for the output beat to be taken.
// One item at a time; the next input beat is taken the cycle after the result is loaded.
// Reset (synchronous, active low) clears the configuration, the blank count,
// last origin and time, the tick history, its running sum and the average.
module frame_pacing_limiter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [fpl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fpl_pkg::TICK_W-1:0]        i_cfg_wdata,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [fpl_pkg::ORIGIN_W-1:0]      i_frame_origin,
    input  logic [fpl_pkg::TIME_W-1:0]        i_timestamp,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_flipped,
    output logic [fpl_pkg::DELAY_W-1:0]       o_pace_wait,
    output logic [fpl_pkg::TICK_W-1:0]        o_average_ticks
);
    import fpl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MD    = 3'd2;
    localparam logic [2:0] S_RING1 = 3'd3;
    localparam logic [2:0] S_RING2 = 3'd4;
    localparam logic [2:0] S_AVG   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // configuration registers
    logic [TICK_W-1:0]   r_ticks_per_blank;
    logic [1:0]          r_speed_mode;
    logic                r_aux_sync;

    // block state
    logic [2:0]          r_state, n_state;
    logic [TICK_W-1:0]   r_blanks;
    logic [ORIGIN_W-1:0] r_last_origin;
    logic [TIME_W-1:0]   r_last_time;
    logic [TICK_W-1:0]   r_hist [HIST_DEPTH];
    logic [SUM_W-1:0]    r_sum;
    logic [TICK_W-1:0]   r_avg;

    // item under work
    logic [ORIGIN_W-1:0] r_origin;
    logic [TIME_W-1:0]   r_ts;
    logic [TICK_W-1:0]   r_elapsed;
    logic                r_flip;
    logic [DELAY_W-1:0]  r_delay;

    // output register
    logic                r_out_valid;
    logic                r_out_flip;
    logic [DELAY_W-1:0]  r_out_delay;
    logic [TICK_W-1:0]   r_out_avg;

    t_md_req             md_req;
    t_md_res             md_res;

    logic                in_beat;
    logic                out_free;
    logic [TICK_W-1:0]   n_elapsed;
    logic [SUM_W-1:0]    n_rounded;
    logic [DELAY_W-1:0]  n_delay;

    assign in_beat   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign n_elapsed = r_ts[TICK_W-1:0] - r_last_time[TICK_W-1:0];
    assign n_rounded = r_sum + ROUND_BIAS;

    // pacing delay: required = ticks_per_blank * blanks, doubled at half speed,
    // minus (elapsed + guard), clamped at zero and saturated to 31 bits; zero when speed mode is off or aux sync is set
    always_comb begin
        logic [TIME_W-1:0] req2;
        logic [TICK_W:0]   need;
        logic [TICK_W+1:0] diff;
        req2 = (r_speed_mode == MODE_HALF) ? {md_res.product[TIME_W-2:0], 1'b0}
                                           : md_res.product;
        need = {1'b0, r_elapsed} + GUARD_TICKS;
        diff = {1'b0, req2[TICK_W:0]} - {1'b0, need};
        priority if (r_speed_mode == MODE_OFF || r_aux_sync) begin
            n_delay = '0;
        end else if (r_speed_mode == MODE_HALF && md_res.product[TIME_W-1]) begin
            n_delay = DELAY_MAX;
        end else if (|req2[TIME_W-1:TICK_W+1]) begin
            n_delay = DELAY_MAX;
        end else if (diff[TICK_W+1]) begin
            n_delay = '0;
        end else if (|diff[TICK_W:DELAY_W]) begin
            n_delay = DELAY_MAX;
        end else begin
            n_delay = diff[DELAY_W-1:0];
        end
    end

    // start the serial unit once a flip is seen; divisor is the blank count
    assign md_req.start        = (r_state == S_CHECK) && (r_origin != r_last_origin);
    assign md_req.dividend     = n_elapsed;
    assign md_req.divisor      = r_blanks;
    assign md_req.multiplicand = r_ticks_per_blank;

    fpl_serial_md u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_res   (md_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_beat) n_state = S_CHECK;
            S_CHECK: n_state = (r_origin != r_last_origin) ? S_MD : S_EMIT;
            S_MD:    if (md_res.done) n_state = S_RING1;
            S_RING1: n_state = S_RING2;
            S_RING2: n_state = S_AVG;
            S_AVG:   n_state = S_EMIT;
            S_EMIT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_ticks_per_blank <= '0;
            r_speed_mode      <= MODE_OFF;
            r_aux_sync        <= 1'b0;
            r_blanks          <= '0;
            r_last_origin     <= '0;
            r_last_time       <= '0;
            r_sum             <= '0;
            r_avg             <= '0;
            r_out_valid       <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++) r_hist[i] <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TICKS_PER_BLANK: r_ticks_per_blank <= i_cfg_wdata;
                    CFG_SPEED_MODE:      r_speed_mode      <= i_cfg_wdata[1:0];
                    CFG_AUX_SYNC:        r_aux_sync        <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            // count every blank; a flip clears the count below
            if (in_beat) r_blanks <= r_blanks + 1'b1;

            // drop the oldest sample from the running sum, then add the new one
            if (r_state == S_RING1) r_sum <= r_sum - {{(SUM_W-TICK_W){1'b0}}, r_hist[HIST_DEPTH-1]};
            if (r_state == S_RING2) begin
                r_sum     <= r_sum + {{(SUM_W-TICK_W){1'b0}}, md_res.quotient};
                r_hist[0] <= md_res.quotient;
                for (int i = 1; i < HIST_DEPTH; i++) r_hist[i] <= r_hist[i-1];
            end

            if (r_state == S_AVG) begin
                r_avg         <= n_rounded[HIST_LOG2 +: TICK_W];
                r_last_origin <= r_origin;
                r_last_time   <= r_ts + {{(TIME_W-DELAY_W){1'b0}}, r_delay};
                r_blanks      <= '0;
            end

            // output register: load when free, release on the taken beat
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_origin <= i_frame_origin;
            r_ts     <= i_timestamp;
        end
        if (r_state == S_CHECK) begin
            r_flip    <= (r_origin != r_last_origin);
            r_delay   <= '0;
            r_elapsed <= n_elapsed;
        end
        if (r_state == S_RING2) r_delay <= n_delay;
        if (r_state == S_EMIT && out_free) begin
            r_out_flip  <= r_flip;
            r_out_delay <= r_delay;
            r_out_avg   <= r_avg;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_flipped       = r_out_flip;
    assign o_pace_wait     = r_out_delay;
    assign o_average_ticks = r_out_avg;

`ifndef SYNTHESIS
    a_noflip_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_flip) |-> (r_delay == '0))
        else $error("delay produced for an unchanged origin");
    a_flip_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_flip) |-> (r_blanks == '0) && (r_last_origin == r_origin))
        else $error("flip did not update blank count or origin");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_res.done |-> (r_state == S_MD))
        else $error("serial unit finished outside its wait state");
`endif

endmodule
